// ----- rtl/tdp_pkg.sv -----
// Shared width constants and controller/datapath interface structs for the trial division core.
`timescale 1ns / 1ps

package tdp_pkg;

  localparam int WIDTH = 16;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture candidate, set divisor to two
    logic div_init;  // clear remainder and bit counter
    logic div_step;  // one restoring-division bit
    logic next_div;  // advance divisor by one
  } tdp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic lt2;        // candidate below two
    logic past_half;  // divisor above half the candidate
    logic bit_last;   // last division bit in progress
    logic rem_zero;   // remainder is zero
  } tdp_sts_t;

endpackage

// ----- rtl/tdp_dp.sv -----
// Datapath: candidate, divisor and a bit-serial restoring remainder unit.
`timescale 1ns / 1ps

module tdp_dp
  import tdp_pkg::*;
(
  input  logic             clk,
  input  logic [WIDTH-1:0] in_candidate,
  input  tdp_cmd_t         cmd,
  output tdp_sts_t         sts
);

  logic [WIDTH-1:0] n_r;
  logic [WIDTH-1:0] d_r;
  logic [WIDTH-2:0] half_r;
  logic [WIDTH-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;

  logic [CNT_W-1:0] bit_idx;
  logic [WIDTH-1:0] shifted;

  assign bit_idx = CNT_W'(WIDTH - 1) - cnt_r;
  assign shifted = {rem_r[WIDTH-2:0], n_r[bit_idx]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r    <= in_candidate;
      half_r <= in_candidate[WIDTH-1:1];
      d_r    <= WIDTH'(2);
    end else if (cmd.next_div) begin
      d_r <= d_r + WIDTH'(1);
    end

    if (cmd.div_init) begin
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      // Remainder stays below the divisor, so the shift never overflows
      rem_r <= (shifted >= d_r) ? (shifted - d_r) : shifted;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign sts.lt2       = ~|n_r[WIDTH-1:1];
  assign sts.past_half = d_r > {1'b0, half_r};
  assign sts.bit_last  = (cnt_r == CNT_W'(WIDTH - 1));
  assign sts.rem_zero  = (rem_r == '0);

endmodule

// ----- rtl/tdp_ctrl.sv -----
// Controller: sequences divisors and division bits, issues the result strobe.
`timescale 1ns / 1ps

module tdp_ctrl
  import tdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output logic     out_is_prime,
  output tdp_cmd_t cmd,
  input  tdp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EVAL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_is_prime_r, out_is_prime_nxt;

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = 1'b0;
    out_is_prime_nxt = out_is_prime_r;
    cmd              = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.lt2) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b0;
          state_nxt        = S_IDLE;
        end else if (sts.past_half) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.bit_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.rem_zero) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = 1'b0;
          state_nxt        = S_IDLE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

// ----- rtl/trial_division_prime_test_core.sv -----
// Top level of the trial division primality tester: controller plus datapath.
`timescale 1ns / 1ps

//  Channel   Ports                         Handshake
//  input     in_candidate[WIDTH-1:0]       beat taken when start && !busy
//  result    out_is_prime                  one-cycle beat marked by out_valid
//
//  Each candidate tries divisors 2 .. floor(n/2) in turn. Each divisor runs
//  a check state, one restoring-remainder bit step per candidate bit and an
//  evaluate state, all through the single bit-serial remainder unit. Reset
//  is synchronous, active low, and returns the controller to idle with no
//  strobe pending. The receiver cannot stall: out_valid lasts exactly one
//  cycle and a new beat may be accepted in that same cycle.

module trial_division_prime_test_core
  import tdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] in_candidate,
  output logic             out_valid,
  output logic             out_is_prime
);

  tdp_cmd_t cmd;
  tdp_sts_t sts;

  // Controller: state machine that walks divisors and division bits
  tdp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime),
    .cmd          (cmd),
    .sts          (sts)
  );

  // Datapath: holds candidate and divisor, computes one remainder bit a cycle while div_step is raised
  tdp_dp u_dp (
    .clk          (clk),
    .in_candidate (in_candidate),
    .cmd          (cmd),
    .sts          (sts)
  );

  // The result strobe only fires as the controller drops back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while controller busy");

  // An accepted beat always puts the controller to work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // Every result passes through the check state, so strobes never repeat back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // Commands to the datapath are mutually exclusive: at most one of the four is raised
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.div_init, cmd.div_step, cmd.next_div}) <= 1)
    else $error("conflicting datapath commands");

endmodule

// ----- bench/trial_division_prime_checker.sv -----
// Checker for the trial division core: predicts each verdict and compares result beats.
`timescale 1ns / 1ps

module trial_division_prime_checker
  import tdp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [WIDTH-1:0] in_candidate,
  input  logic             out_valid,
  input  logic             out_is_prime,
  output int               fail_count,
  output int               pending_count
);

  localparam int REPORT_LIMIT = 10;

  logic             verdict_q[$];
  logic [WIDTH-1:0] candidate_q[$];
  int               mismatches = 0;

  // Try every divisor from two up to half the candidate, bound included.
  function automatic logic prime_by_division(input logic [WIDTH-1:0] n);
    logic [WIDTH-1:0] half;
    logic [WIDTH-1:0] d;
    if (n < 2) return 1'b0;
    half = n >> 1;
    for (d = 2; d <= half; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : check_beats
    logic             want;
    logic [WIDTH-1:0] cand;
    if (!rst_n) begin
      verdict_q.delete();
      candidate_q.delete();
    end else begin
      // Retire the oldest verdict before queuing a beat taken on the same edge.
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("unexpected result beat: is_prime=%0b, nothing pending", out_is_prime);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          cand = candidate_q.pop_front();
          if (out_is_prime !== want) begin
            if (mismatches < REPORT_LIMIT)
              $display("mismatch: candidate %0d is_prime expected %0b got %0b",
                       cand, want, out_is_prime);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        verdict_q.push_back(prime_by_division(in_candidate));
        candidate_q.push_back(in_candidate);
      end
    end
    fail_count    <= mismatches;
    pending_count <= verdict_q.size();
  end

endmodule

// ----- bench/trial_division_prime_test_core_tb.sv -----
// Top of the trial division core bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module trial_division_prime_test_core_tb;
  import tdp_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_BEATS = 80;
  localparam int BLOCK_BEATS  = 20;
  localparam int MAX_GAP      = 13;
  // The slowest correct run is dominated by the largest prime in the
  // directed set; the limit leaves wide margin over it.
  localparam int CYCLE_LIMIT  = 4_000_000;
  // A few divisors' worth of time covers any stray strobe.
  localparam int DRAIN_CYCLES = 4 * (WIDTH + 2);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [WIDTH-1:0] in_candidate = '0;
  logic             busy;
  logic             out_valid;
  logic             out_is_prime;
  int               fail_count;
  int               pending_count;
  int unsigned      cycle_count = 0;

  // Corner candidates: below two, two and three (no divisor tried), four
  // (inclusive bound), squares of primes, all-ones and alternating patterns,
  // and the largest 16-bit prime as the one long beat of the run.
  logic [WIDTH-1:0] corner_values[$] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 9, 25, 49, 169, 961, 251, 256, 1021, 4093,
    65535, 65534, 32768, 32767, 43690, 21845, 65521
  };

  trial_division_prime_test_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_candidate (in_candidate),
    .out_valid    (out_valid),
    .out_is_prime (out_is_prime)
  );

  trial_division_prime_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_candidate  (in_candidate),
    .out_valid     (out_valid),
    .out_is_prime  (out_is_prime),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung controller never drops busy, so cap the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle cycles ahead of a beat; burst phases send back to back.
  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Keep most candidates small so primes stay cheap; large ones are built
  // composite (even or a multiple of three) so they end after a divisor or two.
  function automatic logic [WIDTH-1:0] draw_candidate();
    int unsigned pick;
    logic [WIDTH-1:0] val;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      val = WIDTH'($urandom_range(0, 255));
    end else if (pick < 80) begin
      val = WIDTH'($urandom_range(0, 2047));
    end else if (pick < 90) begin
      val = WIDTH'($urandom());
      val[0] = 1'b0;
    end else begin
      val = WIDTH'(3 * $urandom_range(1, ((1 << WIDTH) - 1) / 3));
    end
    return val;
  endfunction

  // Present one beat at the falling edge and hold it until the core takes it.
  // With no gap, start stays high and only the candidate changes.
  task automatic send_candidate(input logic [WIDTH-1:0] cand, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    // Hold reset, then release it away from the rising edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners, first few back to back.
    foreach (corner_values[k])
      send_candidate(corner_values[k], draw_gap(k < 4));

    // Random beats in blocks, alternating idle-heavy and burst traffic.
    for (int n = 0; n < RANDOM_BEATS; n++)
      send_candidate(draw_candidate(), draw_gap((n / BLOCK_BEATS) % 2 == 1));

    @(negedge clk);
    start <= 1'b0;

    // Drain: wait for every verdict, then watch for stray strobes.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
